// ===== src/lkf_pkg.sv =====
// Shared types and constants of the LED keyframe fade mapper.
package lkf_pkg;

	localparam int COLOR_W    = 8;
	localparam int FADE_REG_W = 7;
	localparam int LEN_REG_W  = 11;
	localparam int LED_ADDR_W = 10;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [FADE_REG_W-1:0] FADE_RESET = 7'd1;
	localparam logic [LEN_REG_W-1:0]  LEN_RESET  = 11'd512;

	// Must stay a power of two so the queue pointers wrap on their own.
	localparam int QUEUE_DEPTH = 2;

	// The delta divider retires one quotient bit per cycle.
	localparam int DIV_CNT_W = $clog2(COLOR_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(COLOR_W - 1);

	typedef enum logic [1:0] {
		REG_FADE_STEP = 2'd0,
		REG_STRIP_A   = 2'd1,
		REG_STRIP_B   = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SETUP,
		BK_RUN
	} back_state_t;

endpackage

// ===== src/lkf_front.sv =====
// Front end: takes keyframes, tracks frame position and queues at most one run descriptor per keyframe.
module lkf_front #(
	parameter int MAX_LEDS = 1024,
	parameter int MAX_FADE = 64,
	localparam int IDX_W  = $clog2(MAX_LEDS),
	localparam int TOT_W  = $clog2(MAX_LEDS + 1),
	localparam int FADE_W = $clog2(MAX_FADE + 1),
	localparam int DESC_W = 6 * lkf_pkg::COLOR_W + IDX_W + FADE_W + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lkf_pkg::COLOR_W-1:0] key_red,
	input  logic [lkf_pkg::COLOR_W-1:0] key_green,
	input  logic [lkf_pkg::COLOR_W-1:0] key_blue,
	input  logic [FADE_W-1:0]           fade_eff,
	input  logic [TOT_W-1:0]            total,
	input  logic                        full,
	output logic                        push,
	output logic [DESC_W-1:0]           push_desc
);

	localparam int POS_W = $clog2(MAX_LEDS + 2 * MAX_FADE + 1);
	localparam int CW    = POS_W + 1;

	typedef struct packed {
		logic [2:0][lkf_pkg::COLOR_W-1:0] prev;
		logic [2:0][lkf_pkg::COLOR_W-1:0] cur;
		logic [IDX_W-1:0]                 idx;
		logic [FADE_W-1:0]                count;
		logic                             ends;
	} desc_t;

	logic [POS_W-1:0]                 key_position_q;
	logic [2:0][lkf_pkg::COLOR_W-1:0] prev_colour_q;

	logic                             accept;
	logic                             stale;
	logic [POS_W-1:0]                 pos;
	logic                             first;
	logic [FADE_W-1:0]                off0;
	logic [CW-1:0]                    idx_full;
	logic [CW-1:0]                    span;
	logic                             emit;
	logic                             ends;
	logic [POS_W-1:0]                 next_pos;
	logic [2:0][lkf_pkg::COLOR_W-1:0] cur;
	desc_t                            desc;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign cur      = {key_red, key_green, key_blue};

	always_comb begin
		// A position left past the frame end by a register change starts a new frame.
		stale = (key_position_q != '0) &&
			(CW'(key_position_q) + CW'(1) >= CW'(total) + CW'(fade_eff));
		pos   = stale ? '0 : key_position_q;
		first = (pos == '0);
		off0  = first ? '0 : fade_eff - FADE_W'(1);

		// The top bit of idx_full marks a run that would start below LED zero.
		idx_full = CW'(pos) - CW'(off0);
		emit     = !idx_full[CW-1] && (idx_full < CW'(total));
		span     = CW'(total) - idx_full;

		ends     = (CW'(pos) + CW'(1) >= CW'(total));
		next_pos = pos + POS_W'(fade_eff);

		// The first keyframe of a frame shows its own colour, so it blends with itself.
		desc.prev  = first ? cur : prev_colour_q;
		desc.cur   = cur;
		desc.idx   = idx_full[IDX_W-1:0];
		desc.count = (span > CW'(off0)) ? off0 + FADE_W'(1) : span[FADE_W-1:0];
		desc.ends  = ends;
	end

	assign push      = accept && (total != '0) && emit;
	assign push_desc = desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_position_q <= '0;
			prev_colour_q  <= '0;
		end else if (accept && (total != '0)) begin
			if (ends) begin
				key_position_q <= '0;
				prev_colour_q  <= '0;
			end else begin
				key_position_q <= next_pos;
				prev_colour_q  <= cur;
			end
		end
	end

endmodule

// ===== src/lkf_queue.sv =====
// Short descriptor queue between the front end and the back end.
module lkf_queue #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int PTR_W = $clog2(lkf_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(lkf_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [lkf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(lkf_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/lkf_back.sv =====
// Back end: one colour step division per keyframe, then one LED per cycle when not stalled.
module lkf_back #(
	parameter int MAX_LEDS = 1024,
	parameter int MAX_FADE = 64,
	localparam int IDX_W  = $clog2(MAX_LEDS),
	localparam int FADE_W = $clog2(MAX_FADE + 1),
	localparam int DESC_W = 6 * lkf_pkg::COLOR_W + IDX_W + FADE_W + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [FADE_W-1:0]              fade_eff,
	input  logic [lkf_pkg::LEN_REG_W-1:0]  strip_a_length,
	input  logic                           q_valid,
	input  logic [DESC_W-1:0]              pop_desc,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lkf_pkg::LED_ADDR_W-1:0] led_address,
	output logic [lkf_pkg::COLOR_W-1:0]    out_red,
	output logic [lkf_pkg::COLOR_W-1:0]    out_green,
	output logic [lkf_pkg::COLOR_W-1:0]    out_blue,
	output logic                           last_of_run,
	output logic                           frame_end
);

	localparam int CLR_W = lkf_pkg::COLOR_W;
	localparam int AW    = ((IDX_W > lkf_pkg::LEN_REG_W) ? IDX_W : lkf_pkg::LEN_REG_W) + 1;

	typedef struct packed {
		logic [2:0][CLR_W-1:0] prev;
		logic [2:0][CLR_W-1:0] cur;
		logic [IDX_W-1:0]      idx;
		logic [FADE_W-1:0]     count;
		logic                  ends;
	} desc_t;

	desc_t desc;

	lkf_pkg::back_state_t state_q, state_d;
	logic [lkf_pkg::DIV_CNT_W-1:0] step_q;

	logic [2:0][CLR_W-1:0]  prev_q;
	logic [2:0]             neg_q;
	logic [2:0][CLR_W-1:0]  quo_q;
	logic [2:0][FADE_W-1:0] rem_q;
	logic [2:0][CLR_W:0]    dq_q;
	logic [2:0][FADE_W-1:0] dr_q;
	logic [2:0][CLR_W-1:0]  q_q;
	logic [2:0][FADE_W-1:0] r_q;
	logic [IDX_W-1:0]       idx_q;
	logic [FADE_W-1:0]      cnt_q;
	logic                   ends_q;

	logic                           out_valid_q;
	logic [lkf_pkg::LED_ADDR_W-1:0] led_address_q;
	logic [2:0][CLR_W-1:0]          colour_q;
	logic                           last_of_run_q;
	logic                           frame_end_q;

	logic                   out_free;
	logic                   out_load;
	logic                   run_last;
	logic [FADE_W:0]        f_ext;

	logic [2:0][CLR_W:0]    diff;
	logic [2:0][CLR_W:0]    diff_neg;
	logic [2:0][CLR_W-1:0]  mag;
	logic [2:0][FADE_W:0]   sh;
	logic [2:0][FADE_W:0]   sh_sub;
	logic [2:0]             ge;
	logic [2:0][FADE_W-1:0] rem_next;
	logic [2:0][CLR_W-1:0]  quo_next;
	logic [2:0][CLR_W:0]    dq_new;
	logic [2:0][FADE_W-1:0] dr_new;
	logic [2:0][CLR_W+1:0]  q0_sum;
	logic [2:0][FADE_W:0]   rs;
	logic [2:0][FADE_W:0]   rs_sub;
	logic [2:0]             wrap;
	logic [2:0][FADE_W-1:0] r_next;
	logic [2:0][CLR_W+1:0]  q_sum;

	logic [AW-1:0]          idx_w;
	logic [AW-1:0]          a_w;
	logic [AW-1:0]          addr_full;

	assign desc     = desc_t'(pop_desc);
	assign out_free = !out_valid_q || out_ready;
	assign run_last = (cnt_q == FADE_W'(1));
	assign f_ext    = {1'b0, fade_eff};

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			lkf_pkg::BK_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					state_d = lkf_pkg::BK_DIV;
				end
			end
			lkf_pkg::BK_DIV: begin
				if (step_q == lkf_pkg::DIV_LAST) begin
					state_d = lkf_pkg::BK_SETUP;
				end
			end
			lkf_pkg::BK_SETUP: begin
				state_d = lkf_pkg::BK_RUN;
			end
			lkf_pkg::BK_RUN: begin
				if (out_free) begin
					out_load = 1'b1;
					if (run_last) begin
						state_d = lkf_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = lkf_pkg::BK_IDLE;
			end
		endcase
	end

	// Per channel: the numerator grows by d = cur - prev from one LED to the next, so
	// floor(d / f) and d mod f are found once and each LED only adds them with a carry.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			diff[c]     = {1'b0, desc.cur[c]} - {1'b0, desc.prev[c]};
			diff_neg[c] = ~diff[c] + (CLR_W + 1)'(1);
			mag[c]      = diff[c][CLR_W] ? diff_neg[c][CLR_W-1:0] : diff[c][CLR_W-1:0];

			sh[c]       = {rem_q[c], quo_q[c][CLR_W-1]};
			sh_sub[c]   = sh[c] - f_ext;
			ge[c]       = (sh[c] >= f_ext);
			rem_next[c] = ge[c] ? sh_sub[c][FADE_W-1:0] : sh[c][FADE_W-1:0];
			quo_next[c] = {quo_q[c][CLR_W-2:0], ge[c]};

			// A negative step rounds toward minus infinity, with the remainder kept positive.
			if (!neg_q[c]) begin
				dq_new[c] = {1'b0, quo_q[c]};
				dr_new[c] = rem_q[c];
			end else if (rem_q[c] == '0) begin
				dq_new[c] = ~{1'b0, quo_q[c]} + (CLR_W + 1)'(1);
				dr_new[c] = '0;
			end else begin
				dq_new[c] = ~{1'b0, quo_q[c]};
				dr_new[c] = fade_eff - rem_q[c];
			end
			q0_sum[c] = {2'b00, prev_q[c]} + {dq_new[c][CLR_W], dq_new[c]};

			rs[c]     = {1'b0, r_q[c]} + {1'b0, dr_q[c]};
			rs_sub[c] = rs[c] - f_ext;
			wrap[c]   = (rs[c] >= f_ext);
			r_next[c] = wrap[c] ? rs_sub[c][FADE_W-1:0] : rs[c][FADE_W-1:0];
			q_sum[c]  = {2'b00, q_q[c]} + {dq_q[c][CLR_W], dq_q[c]} + (CLR_W + 2)'(wrap[c]);
		end
	end

	// LEDs on the first strip are stored in reverse order.
	always_comb begin
		idx_w     = AW'(idx_q);
		a_w       = AW'(strip_a_length);
		addr_full = (idx_w < a_w) ? a_w - idx_w - AW'(1) : idx_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lkf_pkg::BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				step_q <= '0;
			end else if (state_q == lkf_pkg::BK_DIV) begin
				step_q <= step_q + lkf_pkg::DIV_CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int c = 0; c < 3; c++) begin
				prev_q[c] <= desc.prev[c];
				neg_q[c]  <= diff[c][CLR_W];
				quo_q[c]  <= mag[c];
				rem_q[c]  <= '0;
			end
			idx_q  <= desc.idx;
			cnt_q  <= desc.count;
			ends_q <= desc.ends;
		end
		if (state_q == lkf_pkg::BK_DIV) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
		end
		if (state_q == lkf_pkg::BK_SETUP) begin
			for (int c = 0; c < 3; c++) begin
				dq_q[c] <= dq_new[c];
				dr_q[c] <= dr_new[c];
				q_q[c]  <= q0_sum[c][CLR_W-1:0];
				r_q[c]  <= dr_new[c];
			end
		end
		if (out_load) begin
			for (int c = 0; c < 3; c++) begin
				q_q[c] <= q_sum[c][CLR_W-1:0];
				r_q[c] <= r_next[c];
			end
			idx_q         <= idx_q + IDX_W'(1);
			cnt_q         <= cnt_q - FADE_W'(1);
			led_address_q <= addr_full[lkf_pkg::LED_ADDR_W-1:0];
			colour_q      <= q_q;
			last_of_run_q <= run_last;
			frame_end_q   <= run_last && ends_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign led_address = led_address_q;
	assign out_red     = colour_q[2];
	assign out_green   = colour_q[1];
	assign out_blue    = colour_q[0];
	assign last_of_run = last_of_run_q;
	assign frame_end   = frame_end_q;

`ifndef ASSERT_OFF
	a_run_has_leds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkf_pkg::BK_RUN) |-> (cnt_q != '0))
		else $error("back end is walking a run with no LEDs left");

	a_rem_below_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkf_pkg::BK_RUN) |->
		((r_q[0] < fade_eff) && (r_q[1] < fade_eff) && (r_q[2] < fade_eff)))
		else $error("fade remainder reached the fade step");

	a_setup_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkf_pkg::BK_SETUP) |->
		(($past(state_q) == lkf_pkg::BK_DIV) && ($past(step_q) == lkf_pkg::DIV_LAST)))
		else $error("setup entered before the divider finished");

	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_end_q) |-> last_of_run_q)
		else $error("frame end flagged on a word that does not close its run");
`endif

endmodule

// ===== src/led_keyframe_fade_mapper.sv =====
// Top level of the LED keyframe fade mapper: register port, front end, queue and back end.
// The first LED word of a keyframe passes the queue, the back end's idle, divide, setup and
// run states and the output register. The back end writes n LEDs per keyframe (at most the
// fade step), after a bit-serial divider sizes the per-LED colour step, one keyframe at a time.
// The front end takes one keyframe per cycle while the two-entry queue has room.
// Reset clears frame position, previous colour, queue and back end; registers take defaults.
module led_keyframe_fade_mapper #(
	parameter int MAX_LEDS = 1024,
	parameter int MAX_FADE = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lkf_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lkf_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lkf_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lkf_pkg::COLOR_W-1:0]    key_red,
	input  logic [lkf_pkg::COLOR_W-1:0]    key_green,
	input  logic [lkf_pkg::COLOR_W-1:0]    key_blue,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lkf_pkg::LED_ADDR_W-1:0] led_address,
	output logic [lkf_pkg::COLOR_W-1:0]    out_red,
	output logic [lkf_pkg::COLOR_W-1:0]    out_green,
	output logic [lkf_pkg::COLOR_W-1:0]    out_blue,
	output logic                           last_of_run,
	output logic                           frame_end
);

	localparam int IDX_W  = $clog2(MAX_LEDS);
	localparam int TOT_W  = $clog2(MAX_LEDS + 1);
	localparam int FADE_W = $clog2(MAX_FADE + 1);
	localparam int DESC_W = 6 * lkf_pkg::COLOR_W + IDX_W + FADE_W + 1;

	logic [lkf_pkg::FADE_REG_W-1:0] fade_step_q;
	logic [lkf_pkg::LEN_REG_W-1:0]  strip_a_length_q;
	logic [lkf_pkg::LEN_REG_W-1:0]  strip_b_length_q;

	logic                           reg_write;
	lkf_pkg::reg_index_t            reg_index;
	logic [FADE_W-1:0]              fade_eff;
	logic [lkf_pkg::LEN_REG_W:0]    len_sum;
	logic [TOT_W-1:0]               total;

	logic                           q_push;
	logic                           q_full;
	logic                           q_pop;
	logic                           q_valid;
	logic [DESC_W-1:0]              push_desc;
	logic [DESC_W-1:0]              pop_desc;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite;
	assign reg_index = lkf_pkg::reg_index_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_step_q      <= lkf_pkg::FADE_RESET;
			strip_a_length_q <= lkf_pkg::LEN_RESET;
			strip_b_length_q <= lkf_pkg::LEN_RESET;
		end else if (reg_write) begin
			case (reg_index)
				lkf_pkg::REG_FADE_STEP: fade_step_q <= pwdata[lkf_pkg::FADE_REG_W-1:0];
				lkf_pkg::REG_STRIP_A:   strip_a_length_q <= pwdata[lkf_pkg::LEN_REG_W-1:0];
				lkf_pkg::REG_STRIP_B:   strip_b_length_q <= pwdata[lkf_pkg::LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			lkf_pkg::REG_FADE_STEP: prdata = lkf_pkg::APB_DATA_W'(fade_step_q);
			lkf_pkg::REG_STRIP_A:   prdata = lkf_pkg::APB_DATA_W'(strip_a_length_q);
			lkf_pkg::REG_STRIP_B:   prdata = lkf_pkg::APB_DATA_W'(strip_b_length_q);
			default:                prdata = '0;
		endcase
	end

	// A zero step acts as one; a step beyond the supported fade is clamped.
	always_comb begin
		if (fade_step_q == '0) begin
			fade_eff = FADE_W'(1);
		end else if (32'(fade_step_q) > MAX_FADE) begin
			fade_eff = FADE_W'(MAX_FADE);
		end else begin
			fade_eff = FADE_W'(fade_step_q);
		end
		len_sum = {1'b0, strip_a_length_q} + {1'b0, strip_b_length_q};
		if (32'(len_sum) > MAX_LEDS) begin
			total = TOT_W'(MAX_LEDS);
		end else begin
			total = TOT_W'(len_sum);
		end
	end

	lkf_front #(
		.MAX_LEDS (MAX_LEDS),
		.MAX_FADE (MAX_FADE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key_red   (key_red),
		.key_green (key_green),
		.key_blue  (key_blue),
		.fade_eff  (fade_eff),
		.total     (total),
		.full      (q_full),
		.push      (q_push),
		.push_desc (push_desc)
	);

	lkf_queue #(
		.WIDTH (DESC_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_desc),
		.not_empty (q_valid)
	);

	lkf_back #(
		.MAX_LEDS (MAX_LEDS),
		.MAX_FADE (MAX_FADE)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.fade_eff       (fade_eff),
		.strip_a_length (strip_a_length_q),
		.q_valid        (q_valid),
		.pop_desc       (pop_desc),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.led_address    (led_address),
		.out_red        (out_red),
		.out_green      (out_green),
		.out_blue       (out_blue),
		.last_of_run    (last_of_run),
		.frame_end      (frame_end)
	);

endmodule
